FILE: rtl/core/psched_pkg.sv
// shared types, codes and sizes for the periodic task scheduler table
package psched_pkg;

  localparam int SLOT_COUNT  = 8;
  localparam int SLOT_IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int SLOT_ID_W   = 3;
  localparam int HANDLE_W    = 8;
  localparam int TIME_W      = 16;
  localparam int PENDING_W   = 8;

  localparam logic [SLOT_IDX_W-1:0] LAST_SLOT   = SLOT_IDX_W'(SLOT_COUNT - 1);
  localparam logic [PENDING_W-1:0]  PENDING_MAX = '1;

  localparam logic [1:0] KIND_TICK     = 2'd0;
  localparam logic [1:0] KIND_ADD      = 2'd1;
  localparam logic [1:0] KIND_DISPATCH = 2'd2;
  localparam logic [1:0] KIND_DELETE   = 2'd3;

  localparam logic [1:0] STATUS_OK            = 2'd0;
  localparam logic [1:0] STATUS_TABLE_FULL    = 2'd1;
  localparam logic [1:0] STATUS_NO_TASK       = 2'd2;
  localparam logic [1:0] STATUS_NOTHING_READY = 2'd3;

  typedef struct packed {
    logic [1:0]          kind;
    logic [HANDLE_W-1:0] task_handle;
    logic [TIME_W-1:0]   first_delay;
    logic [TIME_W-1:0]   run_period;
    logic [2:0]          target_id;
  } cmd_item_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [SLOT_ID_W-1:0] slot_id;
    logic [HANDLE_W-1:0]  ready_handle;
    logic                 last;
  } rsp_item_t;

  typedef struct packed {
    logic [HANDLE_W-1:0]  handle;
    logic [TIME_W-1:0]    delay;
    logic [TIME_W-1:0]    period;
    logic [PENDING_W-1:0] pending;
    logic                 expired;
  } slot_entry_t;

  typedef struct packed {
    logic        wr;
    logic        emit;
    logic        drop;
    slot_entry_t entry;
  } slot_upd_t;

endpackage

FILE: rtl/core/psched_slot_ram.sv
// slot table memory, one write port and one registered read port
module psched_slot_ram (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [psched_pkg::SLOT_IDX_W-1:0]     waddr,
  input  psched_pkg::slot_entry_t               wdata,
  input  logic                                  re,
  input  logic [psched_pkg::SLOT_IDX_W-1:0]     raddr,
  output psched_pkg::slot_entry_t               rdata
);

  psched_pkg::slot_entry_t mem [psched_pkg::SLOT_COUNT];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/psched_slot_alu.sv
// per-slot update for tick and dispatch scans
module psched_slot_alu (
  input  logic                    dispatch,
  input  logic                    active,
  input  psched_pkg::slot_entry_t entry,
  output psched_pkg::slot_upd_t   upd
);

  logic live;
  logic ready;

  assign live  = active && !entry.expired;
  assign ready = active && (entry.pending != '0);

  always_comb begin
    upd       = '0;
    upd.entry = entry;
    if (dispatch) begin
      upd.wr   = ready;
      upd.emit = ready;
      upd.drop = ready && (entry.period == '0);
      upd.entry.pending = entry.pending - 1'b1;
    end else if (live) begin
      upd.wr = 1'b1;
      if (entry.delay == '0) begin
        if (entry.pending != psched_pkg::PENDING_MAX) begin
          upd.entry.pending = entry.pending + 1'b1;
        end
        upd.entry.delay   = entry.period;
        upd.entry.expired = (entry.period == '0);
      end else begin
        upd.entry.delay = entry.delay - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/periodic_task_scheduler_table_unit.sv
// top level of the periodic task scheduler table
// Add and delete complete in the cycle they are accepted and return one beat. Tick and
// dispatch walk the slot table once through its memory in a read-modify-write loop, one
// slot per cycle while the response side does not hold off a dispatch beat, and close
// with a final beat. One command is in work at a time; the next is taken once the result
// register can hold its first beat.
module periodic_task_scheduler_table_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_ready,
  input  psched_pkg::cmd_item_t cmd,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output psched_pkg::rsp_item_t rsp
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state, state_next;
  logic [psched_pkg::SLOT_IDX_W-1:0] idx, idx_next;
  logic dispatch_mode, dispatch_mode_next;
  logic [psched_pkg::SLOT_COUNT-1:0] active, active_next;
  psched_pkg::rsp_item_t held, held_next;
  logic held_valid, held_valid_next;
  psched_pkg::rsp_item_t rsp_next;
  logic rsp_valid_next;

  logic mem_we;
  logic [psched_pkg::SLOT_IDX_W-1:0] mem_waddr;
  psched_pkg::slot_entry_t mem_wdata;
  logic rd_en;
  logic [psched_pkg::SLOT_IDX_W-1:0] raddr;
  psched_pkg::slot_entry_t rdata;
  psched_pkg::slot_upd_t upd;

  logic out_busy;
  logic accept;
  logic stall;
  logic free_found;
  logic [psched_pkg::SLOT_IDX_W-1:0] free_idx;
  logic [psched_pkg::SLOT_IDX_W-1:0] tgt_idx;
  logic tgt_ok;

  psched_slot_ram u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  psched_slot_alu u_alu (
    .dispatch (dispatch_mode),
    .active   (active[idx]),
    .entry    (rdata),
    .upd      (upd)
  );

  assign out_busy  = rsp_valid && !rsp_ready;
  assign cmd_ready = (state == ST_IDLE) && !out_busy;
  assign accept    = cmd_valid && cmd_ready;
  assign stall     = upd.emit && held_valid && out_busy;

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = psched_pkg::SLOT_COUNT - 1; i >= 0; i--) begin
      if (!active[i]) begin
        free_found = 1'b1;
        free_idx   = psched_pkg::SLOT_IDX_W'(i);
      end
    end
  end

  assign tgt_idx = psched_pkg::SLOT_IDX_W'(cmd.target_id);
  assign tgt_ok  = (int'(cmd.target_id) < psched_pkg::SLOT_COUNT) && active[tgt_idx];

  always_comb begin
    state_next         = state;
    idx_next           = idx;
    dispatch_mode_next = dispatch_mode;
    active_next        = active;
    held_next          = held;
    held_valid_next    = held_valid;
    rsp_next           = rsp;
    rsp_valid_next     = rsp_valid && !rsp_ready;
    mem_we             = 1'b0;
    mem_waddr          = idx;
    mem_wdata          = upd.entry;
    rd_en              = 1'b0;
    raddr              = '0;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd.kind) inside
            psched_pkg::KIND_TICK, psched_pkg::KIND_DISPATCH: begin
              rd_en              = 1'b1;
              raddr              = '0;
              idx_next           = '0;
              dispatch_mode_next = (cmd.kind == psched_pkg::KIND_DISPATCH);
              state_next         = ST_SCAN;
            end
            psched_pkg::KIND_ADD: begin
              rsp_valid_next        = 1'b1;
              rsp_next.ready_handle = '0;
              rsp_next.last         = 1'b1;
              if (free_found) begin
                mem_we                = 1'b1;
                mem_waddr             = free_idx;
                mem_wdata.handle      = cmd.task_handle;
                mem_wdata.delay       = cmd.first_delay;
                mem_wdata.period      = cmd.run_period;
                mem_wdata.pending     = '0;
                mem_wdata.expired     = 1'b0;
                active_next[free_idx] = 1'b1;
                rsp_next.status       = psched_pkg::STATUS_OK;
                rsp_next.slot_id      = psched_pkg::SLOT_ID_W'(free_idx);
              end else begin
                rsp_next.status  = psched_pkg::STATUS_TABLE_FULL;
                rsp_next.slot_id = '0;
              end
            end
            psched_pkg::KIND_DELETE: begin
              rsp_valid_next        = 1'b1;
              rsp_next.slot_id      = cmd.target_id;
              rsp_next.ready_handle = '0;
              rsp_next.last         = 1'b1;
              if (tgt_ok) begin
                active_next[tgt_idx] = 1'b0;
                rsp_next.status      = psched_pkg::STATUS_OK;
              end else begin
                rsp_next.status = psched_pkg::STATUS_NO_TASK;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (!stall) begin
          mem_we = upd.wr;
          if (upd.drop) begin
            active_next[idx] = 1'b0;
          end
          // a new ready slot pushes the previous one out as a non-final beat
          if (upd.emit) begin
            if (held_valid) begin
              rsp_next       = held;
              rsp_valid_next = 1'b1;
            end
            held_next.status       = psched_pkg::STATUS_OK;
            held_next.slot_id      = psched_pkg::SLOT_ID_W'(idx);
            held_next.ready_handle = upd.entry.handle;
            held_next.last         = 1'b0;
            held_valid_next        = 1'b1;
          end
          if (idx == psched_pkg::LAST_SLOT) begin
            state_next = ST_DONE;
          end else begin
            rd_en    = 1'b1;
            raddr    = idx + 1'b1;
            idx_next = idx + 1'b1;
          end
        end
      end
      ST_DONE: begin
        if (!out_busy) begin
          rsp_valid_next = 1'b1;
          if (held_valid) begin
            rsp_next      = held;
            rsp_next.last = 1'b1;
          end else begin
            rsp_next.status       = dispatch_mode ? psched_pkg::STATUS_NOTHING_READY
                                                  : psched_pkg::STATUS_OK;
            rsp_next.slot_id      = '0;
            rsp_next.ready_handle = '0;
            rsp_next.last         = 1'b1;
          end
          held_valid_next = 1'b0;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      active     <= '0;
      held_valid <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      active     <= active_next;
      held_valid <= held_valid_next;
      rsp_valid  <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    idx           <= idx_next;
    dispatch_mode <= dispatch_mode_next;
    held          <= held_next;
    rsp           <= rsp_next;
  end

`ifndef ASSERT_OFF
  a_held_only_in_scan: assert property (@(posedge clk) disable iff (rst)
    held_valid |-> (state == ST_SCAN || state == ST_DONE))
    else $error("held beat outside a scan");

  a_scan_starts_at_zero: assert property (@(posedge clk) disable iff (rst)
    accept && (cmd.kind == psched_pkg::KIND_TICK || cmd.kind == psched_pkg::KIND_DISPATCH)
    |=> (state == ST_SCAN) && (idx == '0))
    else $error("scan did not start at slot zero");

  a_no_same_slot_rmw: assert property (@(posedge clk) disable iff (rst)
    mem_we && rd_en |-> (mem_waddr != raddr))
    else $error("write and read of the same slot in one cycle");

  a_done_no_read: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |-> !rd_en && !mem_we)
    else $error("memory access after scan end");
`endif

endmodule
